FILE: rtl/oupps_pkg.sv
package oupps_pkg;

	localparam int DEF_PATHS = 256;

	localparam int IDX_W   = 8;
	localparam int DT_W    = 24;
	localparam int Z_W     = 16;
	localparam int VAL_W   = 32;
	localparam int CFG_W   = 32;
	localparam int CIDX_W  = 2;

	localparam int EXP_ARG_W  = 49;
	localparam int EXP_RES_W  = 33;
	localparam int SQRT_IN_W  = 64;
	localparam int SQRT_OUT_W = 32;

	localparam logic [CIDX_W-1:0] CFG_MEAN   = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_VAR    = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_RATE   = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_METHOD = 2'd3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic METHOD_EXACT = 1'b0;
	localparam logic METHOD_EULER = 1'b1;

endpackage

FILE: rtl/oupps_ram.sv
module oupps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/oupps_exp.sv
module oupps_exp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [oupps_pkg::EXP_ARG_W-1:0]    arg,
	output logic                               done,
	output logic [oupps_pkg::EXP_RES_W-1:0]    result
);
	import oupps_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_RND   = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_FINAL = 3'd4;

	localparam logic [EXP_ARG_W-1:0] ARG_LIM = EXP_ARG_W'(23) << 32;
	localparam logic [63:0] ONE_Q62 = 64'd1 << 62;
	localparam logic [127:0] HALF_Q62 = 128'd1 << 61;
	localparam logic [4:0] TERMS = 5'd24;
	localparam logic [2:0] SQUARES_LAST = 3'd4;

	logic [2:0]   state_q;
	logic [2:0]   cnt_q;
	logic [2:0]   dcnt_q;
	logic [2:0]   sq_q;
	logic [4:0]   k_q;
	logic         sq_phase_q;
	logic         done_q;
	logic [63:0]  r_q;
	logic [63:0]  sum_q;
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [63:0]  prod_q;
	logic [127:0] acc_q;
	logic [63:0]  num_q;
	logic [4:0]   rem_q;
	logic [EXP_RES_W-1:0] res_q;

	logic [31:0]  lhs;
	logic [31:0]  rhs;
	logic [127:0] acc_rnd;
	logic [63:0]  mq;
	logic [63:0]  num_n;
	logic [4:0]   rem_n;
	logic [5:0]   trial;
	logic [63:0]  sum_n;
	logic [63:0]  sum_rnd;

	always_comb begin
		case (cnt_q)
			3'd0: begin
				lhs = a_q[31:0];
				rhs = b_q[31:0];
			end
			3'd1: begin
				lhs = a_q[31:0];
				rhs = b_q[63:32];
			end
			3'd2: begin
				lhs = a_q[63:32];
				rhs = b_q[31:0];
			end
			3'd3: begin
				lhs = a_q[63:32];
				rhs = b_q[63:32];
			end
			default: begin
				lhs = 32'd0;
				rhs = 32'd0;
			end
		endcase
	end

	assign acc_rnd = acc_q + HALF_Q62;
	assign mq      = acc_rnd[125:62];

	// eight quotient bits per cycle, divisor is the term number
	always_comb begin
		num_n = num_q;
		rem_n = rem_q;
		trial = 6'd0;
		for (int i = 0; i < 8; i++) begin
			trial = {rem_n, num_n[63]};
			if (trial >= {1'b0, k_q}) begin
				rem_n = 5'(trial - {1'b0, k_q});
				num_n = {num_n[62:0], 1'b1};
			end else begin
				rem_n = trial[4:0];
				num_n = {num_n[62:0], 1'b0};
			end
		end
	end

	assign sum_n   = k_q[0] ? (sum_q - num_n) : (sum_q + num_n);
	assign sum_rnd = sum_q + (64'd1 << 29);

	always_ff @(posedge clk) begin
		prod_q <= 64'(lhs) * 64'(rhs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= 3'd0;
			dcnt_q     <= 3'd0;
			sq_q       <= 3'd0;
			k_q        <= 5'd1;
			sq_phase_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (arg >= ARG_LIM) begin
							done_q <= 1'b1;
						end else begin
							k_q        <= 5'd1;
							sq_phase_q <= 1'b0;
							cnt_q      <= 3'd0;
							state_q    <= S_MUL;
						end
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) begin
						state_q <= S_RND;
					end
				end
				S_RND: begin
					cnt_q <= 3'd0;
					if (!sq_phase_q) begin
						dcnt_q  <= 3'd0;
						state_q <= S_DIV;
					end else if (sq_q == SQUARES_LAST) begin
						state_q <= S_FINAL;
					end else begin
						sq_q    <= sq_q + 3'd1;
						state_q <= S_MUL;
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == 3'd7) begin
						cnt_q   <= 3'd0;
						state_q <= S_MUL;
						if (k_q == TERMS) begin
							sq_phase_q <= 1'b1;
							sq_q       <= 3'd0;
						end else begin
							k_q <= k_q + 5'd1;
						end
					end
				end
				S_FINAL: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					res_q  <= '0;
					r_q    <= {arg[38:0], 25'd0};
					sum_q  <= ONE_Q62;
					a_q    <= ONE_Q62;
					b_q    <= {arg[38:0], 25'd0};
				end
			end
			S_MUL: begin
				case (cnt_q)
					3'd1: acc_q <= {64'd0, prod_q};
					3'd2: acc_q <= acc_q + {32'd0, prod_q, 32'd0};
					3'd3: acc_q <= acc_q + {32'd0, prod_q, 32'd0};
					3'd4: acc_q <= acc_q + {prod_q, 64'd0};
					default: acc_q <= acc_q;
				endcase
			end
			S_RND: begin
				if (!sq_phase_q) begin
					num_q <= mq;
					rem_q <= 5'd0;
				end else begin
					sum_q <= mq;
					a_q   <= mq;
					b_q   <= mq;
				end
			end
			S_DIV: begin
				num_q <= num_n;
				rem_q <= rem_n;
				if (dcnt_q == 3'd7) begin
					sum_q  <= sum_n;
					if (k_q == TERMS) begin
						a_q <= sum_n;
						b_q <= sum_n;
					end else begin
						a_q <= num_n;
						b_q <= r_q;
					end
				end
			end
			S_FINAL: begin
				res_q <= sum_rnd[62:30];
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: rtl/oupps_sqrt.sv
module oupps_sqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [oupps_pkg::SQRT_IN_W-1:0]    radicand,
	output logic                               done,
	output logic [oupps_pkg::SQRT_OUT_W-1:0]   root
);
	import oupps_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [SQRT_IN_W-1:0]  v_q;
	logic [SQRT_IN_W-1:0]  res_q;
	logic [SQRT_IN_W-1:0]  bit_q;
	logic [SQRT_OUT_W-1:0] root_q;

	logic [SQRT_IN_W:0]    trial;
	logic                  take;
	logic [SQRT_IN_W-1:0]  res_n;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = {1'b0, v_q} >= trial;
	assign res_n = take ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				busy_q <= start;
			end else if (bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (start) begin
				v_q   <= radicand;
				res_q <= '0;
				bit_q <= SQRT_IN_W'(1) << (SQRT_IN_W - 2);
			end
		end else begin
			if (take) begin
				v_q <= v_q - trial[SQRT_IN_W-1:0];
			end
			res_q <= res_n;
			bit_q <= bit_q >> 2;
			if (bit_q[0]) begin
				root_q <= res_n[SQRT_OUT_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: rtl/ou_process_path_step_unit.sv
// channel  direction  handshake           payload
// cfg      in         cfg_we              cfg_index, cfg_data
// in       in         in_valid/in_stall   opcode, path_index, time_increment,
//                                         normal_sample, start_value
// out      out        out_valid/out_stall out_path, new_value, saturated
//
// one beat in flight; in_stall stays high from acceptance until the result is registered
// load or out-of-range beat: straight to output; euler step: square root (32 steps)
// exact step: two exponential series of 24 terms with a shared
// 32x32 multiplier and a radix-256 divider by the term number
// the output register holds a beat under out_stall; the next beat can be accepted meanwhile
// asynchronous reset clears control and configuration; path memory is undefined until loaded
module ou_process_path_step_unit #(
	parameter int PATHS = oupps_pkg::DEF_PATHS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [oupps_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [oupps_pkg::CFG_W-1:0]      cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             opcode,
	input  logic [oupps_pkg::IDX_W-1:0]      path_index,
	input  logic [oupps_pkg::DT_W-1:0]       time_increment,
	input  logic signed [oupps_pkg::Z_W-1:0] normal_sample,
	input  logic signed [oupps_pkg::VAL_W-1:0] start_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [oupps_pkg::IDX_W-1:0]      out_path,
	output logic signed [oupps_pkg::VAL_W-1:0] new_value,
	output logic                             saturated
);
	import oupps_pkg::*;

	localparam int AW = (PATHS > 1) ? $clog2(PATHS) : 1;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_RD   = 5'd1;
	localparam logic [4:0] S_U    = 5'd2;
	localparam logic [4:0] S_E1   = 5'd3;
	localparam logic [4:0] S_E2   = 5'd4;
	localparam logic [4:0] S_M1   = 5'd5;
	localparam logic [4:0] S_M2   = 5'd6;
	localparam logic [4:0] S_M3   = 5'd7;
	localparam logic [4:0] S_SQ   = 5'd8;
	localparam logic [4:0] S_MZ   = 5'd9;
	localparam logic [4:0] S_M5   = 5'd10;
	localparam logic [4:0] S_EU1  = 5'd11;
	localparam logic [4:0] S_EU2  = 5'd12;
	localparam logic [4:0] S_EU3  = 5'd13;
	localparam logic [4:0] S_EU4  = 5'd14;
	localparam logic [4:0] S_EU5  = 5'd15;
	localparam logic [4:0] S_RND  = 5'd16;
	localparam logic [4:0] S_FIN  = 5'd17;

	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
	localparam logic [65:0] DRIFT_LIM = 66'd1 << 50;
	localparam logic signed [67:0] VAL_MAX = 68'sh0_0000_0000_7FFF_FFFF;
	localparam logic signed [67:0] VAL_MIN = 68'shF_FFFF_FFFF_8000_0000;

	logic [4:0] state_q;

	logic signed [VAL_W-1:0] mu_q;
	logic [23:0]             tau_q;
	logic [23:0]             rate_q;
	logic                    meth_q;

	logic                    out_valid_q;
	logic [IDX_W-1:0]        out_path_q;
	logic signed [VAL_W-1:0] new_value_q;
	logic                    saturated_q;

	logic [IDX_W-1:0]        idx_q;
	logic                    in_range_q;
	logic [DT_W-1:0]         dt_q;
	logic signed [Z_W-1:0]   z_q;
	logic signed [VAL_W-1:0] x_q;
	logic [47:0]             u_q;
	logic [EXP_RES_W-1:0]    e1_q;
	logic [EXP_RES_W-1:0]    e2_q;
	logic [SQRT_OUT_W-1:0]   sd_q;
	logic signed [67:0]      acc_q;
	logic [81:0]             p_q;
	logic [50:0]             drift_q;
	logic signed [VAL_W-1:0] fin_val_q;
	logic                    fin_sat_q;

	logic signed [33:0]      ma;
	logic signed [33:0]      mb;
	logic signed [67:0]      prod_q;

	logic                    in_accept;
	logic                    in_range;
	logic                    fin_go;
	logic [VAL_W-1:0]        rdata;

	logic signed [32:0]      d;
	logic [32:0]             mag;
	logic [32:0]             om_e1;
	logic [32:0]             om_e2;
	logic [81:0]             p_plus;
	logic [65:0]             dq;
	logic [71:0]             tu_sum;
	logic signed [67:0]      r16;
	logic signed [67:0]      r20;
	logic signed [67:0]      rsel;
	logic signed [67:0]      drift_s;

	logic                    exp_start;
	logic [EXP_ARG_W-1:0]    exp_arg;
	logic                    exp_done;
	logic [EXP_RES_W-1:0]    exp_res;
	logic                    sqrt_start;
	logic [SQRT_IN_W-1:0]    sqrt_in;
	logic                    sqrt_done;
	logic [SQRT_OUT_W-1:0]   sqrt_root;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign in_range  = {24'd0, path_index} < PATHS;
	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	assign d     = 33'(mu_q) - 33'(x_q);
	assign mag   = d[32] ? 33'(-d) : 33'(d);
	assign om_e1 = ONE_Q32 - e1_q;
	assign om_e2 = ONE_Q32 - e2_q;

	assign p_plus  = p_q + 82'd32768;
	assign dq      = p_plus[81:16];
	assign tu_sum  = p_q[71:0] + {prod_q[39:0], 32'd0};
	assign drift_s = d[32] ? -$signed({17'd0, drift_q}) : $signed({17'd0, drift_q});

	assign r16  = (acc_q + 68'sd32768) >>> 16;
	assign r20  = (acc_q + 68'sd524288) >>> 20;
	assign rsel = (meth_q == METHOD_EULER) ? r16 : r20;

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_RD: begin
				ma = $signed({10'd0, rate_q});
				mb = $signed({10'd0, dt_q});
			end
			S_E2: begin
				ma = $signed({{2{x_q[31]}}, x_q});
				mb = $signed({1'b0, e1_q});
			end
			S_M1: begin
				ma = $signed({{2{mu_q[31]}}, mu_q});
				mb = $signed({1'b0, om_e1});
			end
			S_M2: begin
				ma = $signed({10'd0, tau_q});
				mb = $signed({1'b0, om_e2});
			end
			S_MZ: begin
				ma = $signed({2'd0, sd_q});
				mb = $signed({{18{z_q[15]}}, z_q});
			end
			S_EU1: begin
				ma = $signed({1'b0, mag});
				mb = $signed({2'd0, u_q[31:0]});
			end
			S_EU2: begin
				ma = $signed({1'b0, mag});
				mb = $signed({18'd0, u_q[47:32]});
			end
			S_EU3: begin
				ma = $signed({2'd0, u_q[31:0]});
				mb = $signed({10'd0, tau_q});
			end
			S_EU4: begin
				ma = $signed({18'd0, u_q[47:32]});
				mb = $signed({10'd0, tau_q});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
	end

	assign exp_start = ((state_q == S_U) && (meth_q == METHOD_EXACT)) ||
	                   ((state_q == S_E1) && exp_done);
	assign exp_arg   = (state_q == S_U) ? {1'b0, prod_q[47:0]} : {u_q, 1'b0};

	assign sqrt_start = (state_q == S_M3) || (state_q == S_EU5);
	assign sqrt_in    = (state_q == S_M3) ? prod_q[63:0] : {3'd0, tu_sum[71:11]};

	oupps_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.arg    (exp_arg),
		.done   (exp_done),
		.result (exp_res)
	);

	oupps_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sqrt_in),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	oupps_ram #(
		.WIDTH (VAL_W),
		.DEPTH (PATHS),
		.AW    (AW)
	) u_paths (
		.clk   (clk),
		.we    (fin_go && in_range_q),
		.waddr (AW'(idx_q)),
		.wdata (fin_val_q),
		.re    (in_accept && in_range && (opcode == OP_STEP)),
		.raddr (AW'(path_index)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q   <= '0;
			tau_q  <= 24'd65536;
			rate_q <= 24'd65536;
			meth_q <= METHOD_EXACT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MEAN:   mu_q   <= cfg_data;
				CFG_VAR:    tau_q  <= cfg_data[23:0];
				CFG_RATE:   rate_q <= cfg_data[23:0];
				CFG_METHOD: meth_q <= cfg_data[0];
				default:    meth_q <= meth_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= (in_range && (opcode == OP_STEP)) ? S_RD : S_FIN;
					end
				end
				S_RD:  state_q <= S_U;
				S_U:   state_q <= (meth_q == METHOD_EULER) ? S_EU1 : S_E1;
				S_E1:  state_q <= exp_done ? S_E2 : S_E1;
				S_E2:  state_q <= exp_done ? S_M1 : S_E2;
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_M3;
				S_M3:  state_q <= S_SQ;
				S_SQ:  state_q <= sqrt_done ? S_MZ : S_SQ;
				S_MZ:  state_q <= S_M5;
				S_M5:  state_q <= S_RND;
				S_EU1: state_q <= S_EU2;
				S_EU2: state_q <= S_EU3;
				S_EU3: state_q <= S_EU4;
				S_EU4: state_q <= S_EU5;
				S_EU5: state_q <= S_SQ;
				S_RND: state_q <= S_FIN;
				S_FIN: state_q <= fin_go ? S_IDLE : S_FIN;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_path_q  <= idx_q;
			new_value_q <= fin_val_q;
			saturated_q <= fin_sat_q;
		end
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					idx_q      <= path_index;
					in_range_q <= in_range;
					dt_q       <= time_increment;
					z_q        <= normal_sample;
					fin_val_q  <= in_range ? start_value : '0;
					fin_sat_q  <= 1'b0;
				end
			end
			S_RD: x_q <= rdata;
			S_U:  u_q <= prod_q[47:0];
			S_E1: begin
				if (exp_done) begin
					e1_q <= exp_res;
				end
			end
			S_E2: begin
				if (exp_done) begin
					e2_q <= exp_res;
				end
			end
			S_M1: acc_q <= prod_q;
			S_M2: acc_q <= acc_q + prod_q;
			S_M3: acc_q <= (acc_q + 68'sd2048) >>> 12;
			S_SQ: begin
				if (sqrt_done) begin
					sd_q <= sqrt_root;
				end
			end
			S_M5: begin
				acc_q <= acc_q + ((meth_q == METHOD_EULER) ? (prod_q <<< 2) : prod_q);
			end
			S_EU2: p_q <= {14'd0, prod_q};
			S_EU3: p_q <= p_q + {prod_q[49:0], 32'd0};
			S_EU4: begin
				drift_q <= (dq > DRIFT_LIM) ? DRIFT_LIM[50:0] : dq[50:0];
				p_q     <= {14'd0, prod_q};
			end
			S_EU5: begin
				acc_q <= $signed({{20{x_q[31]}}, x_q, 16'd0}) + drift_s;
			end
			S_RND: begin
				if (rsel > VAL_MAX) begin
					fin_val_q <= VAL_MAX[31:0];
					fin_sat_q <= 1'b1;
				end else if (rsel < VAL_MIN) begin
					fin_val_q <= VAL_MIN[31:0];
					fin_sat_q <= 1'b1;
				end else begin
					fin_val_q <= rsel[31:0];
					fin_sat_q <= 1'b0;
				end
			end
			default: begin
				fin_sat_q <= fin_sat_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_path  = out_path_q;
	assign new_value = new_value_q;
	assign saturated = saturated_q;

endmodule

FILE: sim/tb_ou_process_path_step_unit.sv
module tb_ou_process_path_step_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import oupps_pkg::*;

	typedef struct {
		logic                    op;
		logic [IDX_W-1:0]        idx;
		logic [DT_W-1:0]         dt;
		logic signed [Z_W-1:0]   z;
		logic signed [VAL_W-1:0] start;
	} beat_t;

	typedef struct {
		logic [IDX_W-1:0]        path;
		logic signed [VAL_W-1:0] val;
		logic                    sat;
	} path_result_t;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam logic [63:0] Q62_UNIT = 64'd1 << 62;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CIDX_W-1:0] cfg_index = CFG_MEAN;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic opcode = OP_LOAD;
	logic [IDX_W-1:0] path_index = '0;
	logic [DT_W-1:0] time_increment = '0;
	logic signed [Z_W-1:0] normal_sample = '0;
	logic signed [VAL_W-1:0] start_value = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [IDX_W-1:0] out_path;
	logic signed [VAL_W-1:0] new_value;
	logic saturated;

	ou_process_path_step_unit dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// predictor state
	longint path_mem [256];
	longint mu_q16;
	longint tau_q16;
	longint rate_q16;
	logic method_q;

	beat_t stim_q[$];
	path_result_t result_q[$];
	int errors = 0;
	bit calm = 0;
	bit in_took = 0;
	int in_gap = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	bit loaded [256];
	int loaded_list[$];

	function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << 61);
		return p[125:62];
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] decay_q32(logic [63:0] v);
		logic [63:0] r, term, acc;
		if (v >= (64'd23 << 32)) return 0;
		r = v << 25;
		term = Q62_UNIT;
		acc = Q62_UNIT;
		for (int k = 1; k <= 24; k++) begin
			term = mul_q62(term, r) / k;
			if (k % 2 == 1) acc = acc - term;
			else acc = acc + term;
		end
		for (int k = 0; k < 5; k++) acc = mul_q62(acc, acc);
		return (acc + (64'd1 << 29)) >> 30;
	endfunction

	function automatic longint round_off(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic path_result_t advance_path(beat_t b);
		path_result_t r;
		longint x, res, mean, sum, d, drift, sdv;
		logic [63:0] u, e1, e2;
		logic [127:0] p;
		r.path = b.idx;
		r.sat = 0;
		if (b.op == OP_LOAD) begin
			path_mem[b.idx] = longint'(b.start);
			r.val = b.start;
			return r;
		end
		x = path_mem[b.idx];
		u = rate_q16 * longint'(b.dt);
		if (method_q == METHOD_EXACT) begin
			e1 = decay_q32(u);
			e2 = decay_q32(u << 1);
			mean = x * longint'(e1) + mu_q16 * longint'((64'd1 << 32) - e1);
			sdv = longint'(floor_sqrt(tau_q16 * ((64'd1 << 32) - e2)));
			sum = round_off(mean, 12) + sdv * longint'(b.z);
			res = round_off(sum, 20);
		end else begin
			d = mu_q16 - x;
			p = {64'd0, (d < 0) ? -d : d} * {64'd0, u};
			p = p + 128'd32768;
			if (p[127:80] != 0 || p[79:16] > (64'd1 << 50)) drift = longint'(1) << 50;
			else drift = longint'(p[79:16]);
			p = {64'd0, u} * {64'd0, tau_q16};
			sdv = longint'(floor_sqrt(p[74:11]));
			sum = x * 65536 + ((d < 0) ? -drift : drift) + sdv * longint'(b.z) * 4;
			res = round_off(sum, 16);
		end
		if (res > 64'sd2147483647) begin
			res = 64'sd2147483647;
			r.sat = 1;
		end else if (res < -64'sd2147483648) begin
			res = -64'sd2147483648;
			r.sat = 1;
		end
		path_mem[b.idx] = res;
		r.val = res[31:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// input driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_took) begin
			end else if (in_gap > 0) begin
				in_gap--;
				in_valid <= 0;
			end else if (stim_q.size() > 0) begin
				beat_t b;
				b = stim_q.pop_front();
				opcode <= b.op;
				path_index <= b.idx;
				time_increment <= b.dt;
				normal_sample <= b.z;
				start_value <= b.start;
				in_valid <= 1;
				in_gap = pick_gap();
			end else begin
				in_valid <= 0;
			end
		end
	end

	// output stall
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1;
		end else begin
			stall_left = pick_gap();
			out_stall <= (stall_left > 0);
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		in_took <= in_valid && !in_stall;
		if (arst_n) begin
			idle_cycles++;
			if (in_valid && !in_stall) begin
				beat_t b;
				b.op = opcode;
				b.idx = path_index;
				b.dt = time_increment;
				b.z = normal_sample;
				b.start = start_value;
				result_q.push_back(advance_path(b));
				idle_cycles = 0;
			end
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				if (result_q.size() == 0) begin
					$error("unexpected beat: path %0d value %0d", out_path, new_value);
					errors++;
				end else begin
					path_result_t e;
					e = result_q.pop_front();
					if (out_path !== e.path) begin
						$error("out_path: expected %0d actual %0d", e.path, out_path);
						errors++;
					end
					if (new_value !== e.val) begin
						$error("new_value: expected %0d actual %0d", e.val, new_value);
						errors++;
					end
					if (saturated !== e.sat) begin
						$error("saturated: expected %0d actual %0d", e.sat, saturated);
						errors++;
					end
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			CFG_MEAN: mu_q16 = longint'(signed'(val));
			CFG_VAR: tau_q16 = longint'(val[23:0]);
			CFG_RATE: rate_q16 = longint'(val[23:0]);
			default: method_q = val[0];
		endcase
	endtask

	task automatic set_all(logic [31:0] mu, logic [23:0] tau, logic [23:0] rate, logic m);
		wait (stim_q.size() == 0 && !in_valid && result_q.size() == 0);
		repeat (10) @(negedge clk);
		write_reg(CFG_MEAN, mu);
		write_reg(CFG_VAR, {8'd0, tau});
		write_reg(CFG_RATE, {8'd0, rate});
		write_reg(CFG_METHOD, {31'd0, m});
	endtask

	task automatic push_beat(logic op, logic [7:0] idx, logic [23:0] dt, logic [15:0] z,
			logic [31:0] start);
		beat_t b;
		b.op = op;
		b.idx = idx;
		b.dt = dt;
		b.z = z;
		b.start = start;
		if (op == OP_LOAD && !loaded[idx]) begin
			loaded[idx] = 1;
			loaded_list.push_back(int'(idx));
		end
		stim_q.push_back(b);
	endtask

	task automatic push_random(int n);
		for (int i = 0; i < n; i++) begin
			logic [23:0] dt;
			dt = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 'h3FFFF));
			if (loaded_list.size() == 0 || $urandom_range(0, 3) == 0)
				push_beat(OP_LOAD, 8'($urandom), dt, 16'($urandom), $urandom);
			else
				push_beat(OP_STEP, 8'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]),
					dt, 16'($urandom), $urandom);
		end
	endtask

	initial begin
		mu_q16 = 0;
		tau_q16 = 65536;
		rate_q16 = 65536;
		method_q = METHOD_EXACT;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// exact mode, reset settings
		push_beat(OP_LOAD, 8'd0, 24'd0, 16'h0000, 32'h7FFFFFFF);
		push_beat(OP_LOAD, 8'd255, 24'hFFFFFF, 16'hFFFF, 32'h80000000);
		push_beat(OP_LOAD, 8'd1, 24'd0, 16'h0000, 32'h00000000);
		push_beat(OP_LOAD, 8'd2, 24'd0, 16'h0000, 32'h00010000);
		push_beat(OP_STEP, 8'd2, 24'd0, 16'h7FFF, 32'h0);
		push_beat(OP_STEP, 8'd2, 24'hFFFFFF, 16'h8000, 32'h0);
		push_beat(OP_STEP, 8'd1, 24'h000100, 16'h7FFF, 32'h0);
		push_beat(OP_STEP, 8'd0, 24'h010000, 16'h7FFF, 32'h0);
		push_beat(OP_STEP, 8'd255, 24'h008000, 16'h8000, 32'hFFFFFFFF);
		push_beat(OP_STEP, 8'd0, 24'h170000, 16'h1000, 32'h0);
		push_random(90);

		// euler, defaults
		set_all(32'd0, 24'd65536, 24'd65536, METHOD_EULER);
		push_beat(OP_LOAD, 8'd3, 24'd0, 16'h0, 32'h7FFFFFFF);
		push_beat(OP_STEP, 8'd3, 24'd0, 16'h7FFF, 32'h0);
		push_beat(OP_STEP, 8'd3, 24'h000400, 16'h7FFF, 32'h0);
		push_random(100);

		// maxima, euler: saturation at the upper bound
		set_all(32'h7FFFFFFF, 24'hFFFFFF, 24'hFFFFFF, METHOD_EULER);
		push_beat(OP_LOAD, 8'd4, 24'd0, 16'h0, 32'h7FFF0000);
		push_beat(OP_STEP, 8'd4, 24'h000010, 16'h7FFF, 32'h0);
		push_beat(OP_LOAD, 8'd5, 24'd0, 16'h0, 32'h80000000);
		push_beat(OP_STEP, 8'd5, 24'hFFFFFF, 16'h8000, 32'h0);
		push_random(100);

		// minima, exact, no idling
		calm = 1;
		set_all(32'h80000000, 24'd0, 24'd0, METHOD_EXACT);
		push_random(100);
		calm = 0;

		set_all(32'h80000000, 24'hFFFFFF, 24'hFFFFFF, METHOD_EXACT);
		push_beat(OP_LOAD, 8'd6, 24'd0, 16'h0, 32'h80000000);
		push_beat(OP_STEP, 8'd6, 24'h000001, 16'h8000, 32'h0);
		push_random(100);

		set_all($urandom, 24'($urandom), 24'($urandom_range(0, 'h3FFFF)), METHOD_EXACT);
		push_random(100);
		set_all($urandom, 24'($urandom), 24'($urandom_range(0, 'h3FFFF)), METHOD_EULER);
		push_random(100);

		wait (stim_q.size() == 0 && !in_valid && result_q.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

FILE: files.f
rtl/oupps_pkg.sv
rtl/oupps_ram.sv
rtl/oupps_exp.sv
rtl/oupps_sqrt.sv
rtl/ou_process_path_step_unit.sv
sim/tb_ou_process_path_step_unit.sv
